// File: hdl/shiprrip_pkg.sv
// shiprrip_pkg: shared types and constants of the rrip dead block replacement policy
// no dependencies; imported by every module of the block
package shiprrip_pkg;

  // fixed field widths
  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int PC_W       = 48;
  localparam int SIG_MAX_W  = 10;
  localparam int COUNT_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [4:0] DECAY_LOG2_MAX = 5'd20;
  localparam logic [1:0] RRPV_TOP       = 2'd3;
  localparam logic [1:0] CTR_TOP        = 2'd3;

  typedef enum logic [0:0] {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REUSE_THR   = 3'd0,
    CFG_DECAY_LOG2  = 3'd1,
    CFG_NEAR_RRPV   = 3'd2,
    CFG_DISTANT     = 3'd3,
    CFG_FOLLOW_THR  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_FOLLOW = 2'd0,
    KIND_SIG    = 2'd1,
    KIND_DIST   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LEAD_RD,
    ST_LEAD_WR,
    ST_IDLE,
    ST_DECAY,
    ST_READ,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic                cmd;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [PC_W-1:0]     pc;
    logic                was_hit;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] applied_rrpv;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reuse_thr;
    logic [4:0] decay_log2;
    logic [1:0] near_rrpv;
    logic [1:0] distant_rrpv;
    logic [9:0] follow_thr;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reuse_thr:    2'd1,
    decay_log2:   5'd13,
    near_rrpv:    2'd0,
    distant_rrpv: 2'd2,
    follow_thr:   10'd511
  };

  // classified transaction handed from front to back
  typedef struct packed {
    logic                 cmd;
    logic [SET_IN_W-1:0]  set_index;
    logic [WAY_IN_W-1:0]  way_index;
    logic [SIG_MAX_W-1:0] sig;
    logic                 was_hit;
    logic                 decay;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// File: hdl/shiprrip_front.sv
// shiprrip_front: accepts transactions, reduces set and way, forms the signature,
// counts updates and flags the periodic dead counter decay; uses shiprrip_pkg
module shiprrip_front import shiprrip_pkg::*; #(
  parameter int NUM_SETS  = 2048,
  parameter int NUM_WAYS  = 16,
  parameter int SIG_WIDTH = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output work_t    work_o
);

  logic [COUNT_W-1:0]  count_q, count_d, count_next;
  logic [4:0]          k;
  logic [COUNT_W:0]    mask_w;
  logic [SET_IN_W-1:0] set_m;
  logic [SIG_WIDTH-1:0] sig;

  // set modulo the set count, one restoring step per quotient bit
  function automatic logic [SET_IN_W-1:0] set_mod(input logic [SET_IN_W-1:0] v);
    logic [17:0] r;
    r = 18'(v);
    for (int j = 4; j >= 0; j--) begin
      if (r >= (18'(NUM_SETS) << j)) begin
        r = r - (18'(NUM_SETS) << j);
      end
    end
    return SET_IN_W'(r);
  endfunction

  function automatic logic [WAY_IN_W-1:0] way_mod(input logic [WAY_IN_W-1:0] v);
    logic [8:0] r;
    r = 9'(v);
    for (int j = 2; j >= 0; j--) begin
      if (r >= (9'(NUM_WAYS) << j)) begin
        r = r - (9'(NUM_WAYS) << j);
      end
    end
    return WAY_IN_W'(r);
  endfunction

  // classification
  always_comb begin
    count_next = count_q + COUNT_W'(1);
    k          = (cfg_i.decay_log2 > DECAY_LOG2_MAX) ? DECAY_LOG2_MAX : cfg_i.decay_log2;
    mask_w     = ((COUNT_W+1)'(1) << k) - (COUNT_W+1)'(1);
    set_m      = set_mod(item_i.set_index);
    sig        = item_i.pc[2 +: SIG_WIDTH] ^ set_m[SIG_WIDTH-1:0];

    work_o.cmd       = item_i.cmd;
    work_o.set_index = set_m;
    work_o.way_index = way_mod(item_i.way_index);
    work_o.sig       = SIG_MAX_W'(sig);
    work_o.was_hit   = item_i.was_hit;
    work_o.decay     = (item_i.cmd == CMD_UPDATE) &&
                       ((count_next & mask_w[COUNT_W-1:0]) == '0);

    count_d = count_q;
    if (accept_i && item_i.cmd == CMD_UPDATE) begin
      count_d = count_next;
    end
  end

  // update counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// File: hdl/shiprrip_fifo.sv
// shiprrip_fifo: two entry queue of classified transactions between front and back
// uses shiprrip_pkg
module shiprrip_fifo import shiprrip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  work_t      data_i,
  input  logic       rd_i,
  output work_t      data_o,
  output fifo_stat_t stat_o
);

  work_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign data_o       = mem_q[rptr_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wptr_q <= ~wptr_q;
      end
      if (rd_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/shiprrip_back.sv
// shiprrip_back: replacement state memories, reset clearing and leader setup,
// decay sweep, victim search and update execution, result register; uses shiprrip_pkg
module shiprrip_back import shiprrip_pkg::*; #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIG_WIDTH      = 6,
  parameter int LEADER_COUNT   = 32,
  parameter int SELECTOR_WIDTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  fifo_stat_t q_stat_i,
  input  work_t      q_data_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o,
  output logic       init_done_o
);

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SIG_N  = 1 << SIG_WIDTH;
  localparam int LEAD_W = $clog2(LEADER_COUNT + 1);
  localparam int ARW    = SET_W + 2;
  localparam int CMP_W  = (SELECTOR_WIDTH > 10) ? SELECTOR_WIDTH : 10;
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);
  localparam logic [SET_W-1:0] LEAD_B0  = SET_W'(13 % NUM_SETS);
  localparam logic [LEAD_W-1:0] LEAD_LAST = LEAD_W'(LEADER_COUNT - 1);
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX  = '1;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_INIT = SEL_MAX >> 1;

  typedef logic [NUM_WAYS-1:0][1:0]           lane2_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sig_row_t;
  typedef logic [SIG_N-1:0][1:0]              ctr_row_t;

  // row memories, one row per set
  lane2_row_t           rrpv_mem  [NUM_SETS];
  sig_row_t             sig_mem   [NUM_SETS];
  lane2_row_t           dead_mem  [NUM_SETS];
  logic [NUM_WAYS-1:0]  valid_mem [NUM_SETS];
  ctr_row_t             ctr_mem   [NUM_SETS];
  logic [1:0]           kind_mem  [NUM_SETS];

  lane2_row_t          rd_rrpv_q, rd_dead_q;
  sig_row_t            rd_sig_q;
  logic [NUM_WAYS-1:0] rd_valid_q;
  ctr_row_t            rd_ctr_q;
  logic [1:0]          rd_kind_q;

  back_state_e state_q, state_d;
  logic [SET_W-1:0]  ptr_q, ptr_d;
  logic              drd_done_q, drd_done_d;
  logic              dwr_v_q, dwr_v_d;
  logic [SET_W-1:0]  dwr_a_q, dwr_a_d;
  logic [LEAD_W-1:0] lead_i_q, lead_i_d;
  logic              lead_ph_q, lead_ph_d;
  logic [SET_W-1:0]  lead_a_q, lead_a_d, lead_b_q, lead_b_d;
  logic [ARW-1:0]    na, nb;
  logic [SELECTOR_WIDTH-1:0] psel_q, psel_d;
  logic [1:0]        round_q, round_d;
  lane2_row_t        age_q, age_d;
  work_t             cur_q, cur_d;
  logic              out_valid_q, out_set;
  out_item_t         out_q, out_d;

  // memory port controls
  logic             re;
  logic [SET_W-1:0] ra, wa;
  logic             we_rrpv, we_sig, we_dead, we_valid, we_ctr, we_kind;
  lane2_row_t          wd_rrpv, wd_dead;
  sig_row_t            wd_sig;
  logic [NUM_WAYS-1:0] wd_valid;
  ctr_row_t            wd_ctr;
  logic [1:0]          wd_kind;

  // execution datapath
  logic [WAY_W-1:0]     w;
  logic [SIG_WIDTH-1:0] s, old_sig;
  logic [SET_W-1:0]     sa;
  lane2_row_t           rrpv_cur, aged, dead_decay, upd_rrpv, upd_dead;
  sig_row_t             upd_sig;
  logic [NUM_WAYS-1:0]  upd_valid;
  ctr_row_t             ctr_hit, ctr_miss;
  logic                 any_top, reuse, dead_v, guided;
  logic [3:0]           vic;
  logic [1:0]           ins, applied;
  logic [SELECTOR_WIDTH-1:0] psel_upd;

  assign init_done_o = (state_q != ST_CLEAR) && (state_q != ST_LEAD_RD) &&
                       (state_q != ST_LEAD_WR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next leader set positions
  always_comb begin
    na = ARW'(lead_a_q) + ARW'(37);
    if (na >= ARW'(NUM_SETS)) begin
      na = na - ARW'(NUM_SETS);
    end
    nb = ARW'(lead_b_q) + ARW'(71);
    if (nb >= ARW'(NUM_SETS)) begin
      nb = nb - ARW'(NUM_SETS);
    end
    if (nb >= ARW'(NUM_SETS)) begin
      nb = nb - ARW'(NUM_SETS);
    end
  end

  // victim search, update edits and decay of one row
  always_comb begin
    w        = WAY_W'(cur_q.way_index);
    s        = SIG_WIDTH'(cur_q.sig);
    sa       = SET_W'(cur_q.set_index);
    old_sig  = rd_sig_q[w];
    rrpv_cur = (round_q == 2'd0) ? rd_rrpv_q : age_q;

    any_top = 1'b0;
    vic     = 4'd0;
    for (int wi = NUM_WAYS - 1; wi >= 0; wi--) begin
      aged[wi] = (rrpv_cur[wi] == RRPV_TOP) ? RRPV_TOP : rrpv_cur[wi] + 2'd1;
      if (rrpv_cur[wi] == RRPV_TOP) begin
        any_top = 1'b1;
        vic     = 4'(wi);
      end
    end

    for (int wi = 0; wi < NUM_WAYS; wi++) begin
      dead_decay[wi] = (rd_dead_q[wi] == 2'd0) ? 2'd0 : rd_dead_q[wi] - 2'd1;
    end

    ctr_hit = rd_ctr_q;
    if (rd_ctr_q[s] != CTR_TOP) begin
      ctr_hit[s] = rd_ctr_q[s] + 2'd1;
    end
    ctr_miss = rd_ctr_q;
    if (rd_valid_q[w] && rd_ctr_q[old_sig] != 2'd0) begin
      ctr_miss[old_sig] = rd_ctr_q[old_sig] - 2'd1;
    end

    reuse  = ctr_miss[s] >= cfg_i.reuse_thr;
    dead_v = (rd_dead_q[w] == 2'd0);
    case (kind_e'(rd_kind_q))
      KIND_SIG:  guided = 1'b1;
      KIND_DIST: guided = 1'b0;
      default:   guided = CMP_W'(psel_q) >= CMP_W'(cfg_i.follow_thr);
    endcase
    ins     = (guided && reuse && !dead_v) ? cfg_i.near_rrpv : cfg_i.distant_rrpv;
    applied = cur_q.was_hit ? cfg_i.near_rrpv : ins;

    upd_rrpv     = rd_rrpv_q;
    upd_rrpv[w]  = applied;
    upd_sig      = rd_sig_q;
    upd_sig[w]   = s;
    upd_valid    = rd_valid_q;
    upd_valid[w] = 1'b1;
    upd_dead     = rd_dead_q;
    if (cur_q.was_hit) begin
      upd_dead[w] = (rd_dead_q[w] == 2'd3) ? 2'd3 : rd_dead_q[w] + 2'd1;
    end else begin
      upd_dead[w] = 2'd0;
    end

    psel_upd = psel_q;
    if (!cur_q.was_hit) begin
      case (kind_e'(rd_kind_q))
        KIND_SIG:  if (psel_q != SEL_MAX) psel_upd = psel_q + 1'b1;
        KIND_DIST: if (psel_q != '0) psel_upd = psel_q - 1'b1;
        default:   psel_upd = psel_q;
      endcase
    end
  end

  // sequencer: next state and memory port controls
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    drd_done_d = drd_done_q;
    dwr_v_d    = 1'b0;
    dwr_a_d    = ptr_q;
    lead_i_d   = lead_i_q;
    lead_ph_d  = lead_ph_q;
    lead_a_d   = lead_a_q;
    lead_b_d   = lead_b_q;
    psel_d     = psel_q;
    round_d    = round_q;
    age_d      = age_q;
    cur_d      = cur_q;
    out_set    = 1'b0;
    out_d      = out_q;
    q_pop_o    = 1'b0;
    re         = 1'b0;
    ra         = sa;
    wa         = sa;
    we_rrpv    = 1'b0;
    we_sig     = 1'b0;
    we_dead    = 1'b0;
    we_valid   = 1'b0;
    we_ctr     = 1'b0;
    we_kind    = 1'b0;
    wd_rrpv    = upd_rrpv;
    wd_sig     = upd_sig;
    wd_dead    = upd_dead;
    wd_valid   = upd_valid;
    wd_ctr     = cur_q.was_hit ? ctr_hit : ctr_miss;
    wd_kind    = KIND_FOLLOW;

    case (state_q)
      ST_CLEAR: begin
        wa       = ptr_q;
        we_rrpv  = 1'b1;
        we_sig   = 1'b1;
        we_dead  = 1'b1;
        we_valid = 1'b1;
        we_ctr   = 1'b1;
        we_kind  = 1'b1;
        wd_rrpv  = '1;
        wd_sig   = '0;
        wd_dead  = '1;
        wd_valid = '0;
        wd_ctr   = {SIG_N{2'b01}};
        wd_kind  = KIND_FOLLOW;
        ptr_d    = ptr_q + 1'b1;
        if (ptr_q == SET_LAST) begin
          state_d   = ST_LEAD_RD;
          lead_i_d  = '0;
          lead_ph_d = 1'b0;
          lead_a_d  = '0;
          lead_b_d  = LEAD_B0;
        end
      end
      ST_LEAD_RD: begin
        re      = 1'b1;
        ra      = lead_ph_q ? lead_b_q : lead_a_q;
        state_d = ST_LEAD_WR;
      end
      ST_LEAD_WR: begin
        wa      = lead_ph_q ? lead_b_q : lead_a_q;
        we_kind = (kind_e'(rd_kind_q) == KIND_FOLLOW);
        wd_kind = lead_ph_q ? KIND_DIST : KIND_SIG;
        state_d = ST_LEAD_RD;
        if (!lead_ph_q) begin
          lead_ph_d = 1'b1;
        end else if (lead_i_q == LEAD_LAST) begin
          state_d = ST_IDLE;
        end else begin
          lead_ph_d = 1'b0;
          lead_i_d  = lead_i_q + 1'b1;
          lead_a_d  = SET_W'(na);
          lead_b_d  = SET_W'(nb);
        end
      end
      ST_IDLE: begin
        if (!q_stat_i.empty && (!out_valid_q || pop_i)) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          round_d = 2'd0;
          if (q_data_i.decay) begin
            state_d    = ST_DECAY;
            ptr_d      = '0;
            drd_done_d = 1'b0;
          end else begin
            re      = 1'b1;
            ra      = SET_W'(q_data_i.set_index);
            state_d = ST_EXEC;
          end
        end
      end
      ST_DECAY: begin
        // read one row per cycle, write it back decremented in the cycle after
        if (!drd_done_q) begin
          re      = 1'b1;
          ra      = ptr_q;
          ptr_d   = ptr_q + 1'b1;
          dwr_v_d = 1'b1;
          if (ptr_q == SET_LAST) begin
            drd_done_d = 1'b1;
          end
        end
        if (dwr_v_q) begin
          wa      = dwr_a_q;
          we_dead = 1'b1;
          wd_dead = dead_decay;
          if (dwr_a_q == SET_LAST) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        re      = 1'b1;
        ra      = sa;
        round_d = 2'd0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cur_q.cmd == CMD_UPDATE) begin
          we_rrpv  = 1'b1;
          we_sig   = 1'b1;
          we_dead  = 1'b1;
          we_valid = 1'b1;
          we_ctr   = 1'b1;
          psel_d   = psel_upd;
          out_set  = 1'b1;
          out_d    = '{victim_way: 4'd0, applied_rrpv: applied};
          state_d  = ST_IDLE;
        end else if (any_top) begin
          we_rrpv = (round_q != 2'd0);
          wd_rrpv = rrpv_cur;
          out_set = 1'b1;
          out_d   = '{victim_way: vic, applied_rrpv: 2'd0};
          state_d = ST_IDLE;
        end else begin
          age_d   = aged;
          round_d = round_q + 2'd1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      drd_done_q  <= 1'b0;
      dwr_v_q     <= 1'b0;
      dwr_a_q     <= '0;
      lead_i_q    <= '0;
      lead_ph_q   <= 1'b0;
      lead_a_q    <= '0;
      lead_b_q    <= '0;
      psel_q      <= SEL_INIT;
      round_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      drd_done_q <= drd_done_d;
      dwr_v_q    <= dwr_v_d;
      dwr_a_q    <= dwr_a_d;
      lead_i_q   <= lead_i_d;
      lead_ph_q  <= lead_ph_d;
      lead_a_q   <= lead_a_d;
      lead_b_q   <= lead_b_d;
      psel_q     <= psel_d;
      round_q    <= round_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    age_q <= age_d;
    out_q <= out_d;
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_rrpv_q  <= rrpv_mem[ra];
      rd_sig_q   <= sig_mem[ra];
      rd_dead_q  <= dead_mem[ra];
      rd_valid_q <= valid_mem[ra];
      rd_ctr_q   <= ctr_mem[ra];
      rd_kind_q  <= kind_mem[ra];
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (we_rrpv) begin
      rrpv_mem[wa] <= wd_rrpv;
    end
    if (we_sig) begin
      sig_mem[wa] <= wd_sig;
    end
    if (we_dead) begin
      dead_mem[wa] <= wd_dead;
    end
    if (we_valid) begin
      valid_mem[wa] <= wd_valid;
    end
    if (we_ctr) begin
      ctr_mem[wa] <= wd_ctr;
    end
    if (we_kind) begin
      kind_mem[wa] <= wd_kind;
    end
  end

endmodule

// File: hdl/ship_rrip_dead_block_replacement.sv
// ship_rrip_dead_block_replacement: top level of the rrip dead block replacement policy
// depends on shiprrip_pkg, shiprrip_front, shiprrip_fifo and shiprrip_back
//
// channel   direction  handshake                 payload
// input     in         push / full               in_item_i   (in_item_t)
// result    out        pop / empty               out_item_o  (out_item_t)
// config    in         cfg_we_i, cfg_idx_i       cfg_wdata_i (10 bits)
//
// after reset full stays high while every row is cleared, one memory row per cycle,
// and then the leader sets are marked.
// a victim query in the back end reads the row, then runs one search round per cycle,
// with up to three ageing rounds; an update reads the row and then writes it back.
// every 2^k updates the dead counter decay sweeps all rows first.
// the two entry queue lets the front accept while the back works or the result waits.
module ship_rrip_dead_block_replacement import shiprrip_pkg::*; #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIG_WIDTH      = 6,
  parameter int LEADER_COUNT   = 32,
  parameter int SELECTOR_WIDTH = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  work_t      work, q_data;
  fifo_stat_t q_stat;
  logic       accept, q_pop, out_valid, init_done;

  assign full   = q_stat.full || !init_done;
  assign accept = push && !full;
  assign empty  = !out_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_REUSE_THR:  cfg_q.reuse_thr    <= cfg_wdata_i[1:0];
        CFG_DECAY_LOG2: cfg_q.decay_log2   <= cfg_wdata_i[4:0];
        CFG_NEAR_RRPV:  cfg_q.near_rrpv    <= cfg_wdata_i[1:0];
        CFG_DISTANT:    cfg_q.distant_rrpv <= cfg_wdata_i[1:0];
        CFG_FOLLOW_THR: cfg_q.follow_thr   <= cfg_wdata_i[9:0];
        default:        cfg_q              <= cfg_q;
      endcase
    end
  end

  // front: classify
  shiprrip_front #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .SIG_WIDTH (SIG_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (in_item_i),
    .work_o   (work)
  );

  // queue between front and back
  shiprrip_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept),
    .data_i (work),
    .rd_i   (q_pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  // back: execute
  shiprrip_back #(
    .NUM_SETS       (NUM_SETS),
    .NUM_WAYS       (NUM_WAYS),
    .SIG_WIDTH      (SIG_WIDTH),
    .LEADER_COUNT   (LEADER_COUNT),
    .SELECTOR_WIDTH (SELECTOR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o),
    .init_done_o (init_done)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !q_stat.full) else $error("queue written while full");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty) else $error("queue read while empty");
  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> (full && empty)) else $error("transaction during reset clearing");
`endif

endmodule
